### rtl/trd_pkg.sv
// Shared types and constants of the tile run-length decoder.
// Depends on nothing; imported by every module of the decoder.
`timescale 1ns / 1ps

package trd_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned RUN_LEN_W   = 16;
  localparam int unsigned RUN_COUNT_W = 15;
  localparam int unsigned TILE_DIM_W  = 7;
  localparam int unsigned PLANES_W    = 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [BYTE_W-1:0] LIT_LONG_HDR = 8'h80;
  localparam logic [BYTE_W-1:0] REP_LONG_HDR = 8'h7F;

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_COUNT_HI = 3'd1,
    PH_COUNT_LO = 3'd2,
    PH_VALUE    = 3'd3,
    PH_LITERAL  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0]      run_value;
    logic [RUN_COUNT_W-1:0] run_count;
    logic                   tile_done;
    logic                   tile_short;
  } result_t;

  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } cmd_t;

endpackage

### rtl/trd_front.sv
// Front end of the tile run-length decoder: parses compressed bytes, clips runs to
// the room left in the tile and emits at most one command per byte. Uses trd_pkg.
`timescale 1ns / 1ps

module trd_front import trd_pkg::*; #(
  parameter int unsigned TOT_W = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_last,
  input  logic [TOT_W-1:0]  total,
  output logic              cmd_push,
  output cmd_t              cmd
);

  localparam int unsigned CW = (TOT_W > RUN_LEN_W) ? TOT_W : RUN_LEN_W;

  phase_t                 phase_r, phase_nxt;
  logic                   lit_r, lit_nxt;
  logic [RUN_LEN_W-1:0]   rem_r, rem_nxt;
  logic [BYTE_W-1:0]      chi_r, chi_nxt;
  logic [TOT_W-1:0]       bw_r, bw_nxt;
  logic                   fin_r, fin_nxt;

  logic [BYTE_W-1:0]      va;
  logic [RUN_LEN_W-1:0]   ca, cb, rem_dec, cnt_word;
  logic [CW-1:0]          room0, room1, room2, c_a, c_b;
  logic                   has_a, has_b, is_full, tile_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      lit_r   <= 1'b0;
      rem_r   <= '0;
      chi_r   <= '0;
      bw_r    <= '0;
      fin_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      lit_r   <= lit_nxt;
      rem_r   <= rem_nxt;
      chi_r   <= chi_nxt;
      bw_r    <= bw_nxt;
      fin_r   <= fin_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    lit_nxt   = lit_r;
    rem_nxt   = rem_r;
    chi_nxt   = chi_r;
    bw_nxt    = bw_r;
    fin_nxt   = fin_r;
    va        = '0;
    ca        = '0;
    cb        = '0;
    cmd       = '0;
    cmd_push  = 1'b0;
    rem_dec   = rem_r - RUN_LEN_W'(1);
    cnt_word  = {chi_r, in_byte};
    room0     = (CW'(bw_r) < CW'(total)) ? CW'(total) - CW'(bw_r) : '0;

    if (in_valid && !fin_r) begin
      unique case (phase_r)
        PH_COUNT_HI: begin
          chi_nxt = in_byte;
          if (in_last) begin
            ca = {in_byte, 8'h00};
          end else begin
            phase_nxt = PH_COUNT_LO;
          end
        end
        PH_COUNT_LO: begin
          rem_nxt = cnt_word;
          if (in_last) begin
            ca = cnt_word;
          end else if (!lit_r) begin
            phase_nxt = PH_VALUE;
          end else begin
            phase_nxt = (cnt_word != '0) ? PH_LITERAL : PH_HEADER;
          end
        end
        PH_VALUE: begin
          va        = in_byte;
          ca        = rem_r;
          rem_nxt   = '0;
          phase_nxt = PH_HEADER;
        end
        PH_LITERAL: begin
          va      = in_byte;
          ca      = RUN_LEN_W'(1);
          rem_nxt = rem_dec;
          if (in_last) begin
            cb = rem_dec;
          end
          if (rem_dec == '0) begin
            phase_nxt = PH_HEADER;
          end
        end
        default: begin
          phase_nxt = PH_HEADER;
          if (!in_last) begin
            if (in_byte[BYTE_W-1]) begin
              lit_nxt   = 1'b1;
              rem_nxt   = RUN_LEN_W'(9'd256 - {1'b0, in_byte});
              phase_nxt = (in_byte == LIT_LONG_HDR) ? PH_COUNT_HI : PH_LITERAL;
            end else begin
              lit_nxt   = 1'b0;
              rem_nxt   = RUN_LEN_W'({1'b0, in_byte} + 9'd1);
              phase_nxt = (in_byte == REP_LONG_HDR) ? PH_COUNT_HI : PH_VALUE;
            end
          end
        end
      endcase
    end

    c_a      = (CW'(ca) < room0) ? CW'(ca) : room0;
    room1    = room0 - c_a;
    c_b      = (CW'(cb) < room1) ? CW'(cb) : room1;
    room2    = room1 - c_b;
    has_a    = (c_a != '0);
    has_b    = (c_b != '0);
    is_full  = (room2 == '0);
    tile_end = is_full || in_last;

    if (has_a) begin
      cmd.r0.run_value = va;
      cmd.r0.run_count = RUN_COUNT_W'(c_a);
    end else if (has_b) begin
      cmd.r0.run_count = RUN_COUNT_W'(c_b);
    end
    cmd.two          = has_a && has_b;
    cmd.r1.run_count = RUN_COUNT_W'(c_b);
    if (cmd.two) begin
      cmd.r1.tile_done  = tile_end;
      cmd.r1.tile_short = tile_end && !is_full;
    end else begin
      cmd.r0.tile_done  = tile_end;
      cmd.r0.tile_short = tile_end && !is_full;
    end

    if (in_valid) begin
      if (fin_r) begin
        if (in_last) begin
          fin_nxt   = 1'b0;
          bw_nxt    = '0;
          phase_nxt = PH_HEADER;
        end
      end else begin
        cmd_push = has_a || has_b || tile_end;
        bw_nxt   = bw_r + TOT_W'(c_a) + TOT_W'(c_b);
        if (tile_end) begin
          phase_nxt = PH_HEADER;
          rem_nxt   = '0;
          if (in_last) begin
            bw_nxt  = '0;
            fin_nxt = 1'b0;
          end else begin
            fin_nxt = 1'b1;
          end
        end
      end
    end
  end

endmodule

### rtl/trd_cmd_queue.sv
// Short command queue between the front and back ends of the decoder.
// Holds QUEUE_DEPTH command words; uses trd_pkg.
`timescale 1ns / 1ps

module trd_cmd_queue import trd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  input  logic rd_en,
  output cmd_t rd_cmd,
  output logic q_full,
  output logic q_empty
);

  cmd_t                     mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QUEUE_PTR_W:0]     cnt_r, cnt_nxt;
  logic                     do_wr, do_rd;

  assign q_full  = (cnt_r == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_cmd  = mem_r[rd_r];
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;

  always_comb begin
    wr_nxt  = do_wr ? wr_r + QUEUE_PTR_W'(1) : wr_r;
    rd_nxt  = do_rd ? rd_r + QUEUE_PTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + (QUEUE_PTR_W + 1)'(do_wr) - (QUEUE_PTR_W + 1)'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_r] <= wr_cmd;
    end
  end

endmodule

### rtl/trd_back.sv
// Back end of the decoder: unpacks each command word into one or two result
// words and holds the oldest in an output register. Uses trd_pkg.
`timescale 1ns / 1ps

module trd_back import trd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cmd_t    head,
  input  logic    q_empty,
  output logic    q_pop,
  input  logic    pop,
  output logic    empty,
  output result_t res
);

  logic    vld_r, vld_nxt;
  logic    sub_r, sub_nxt;
  result_t res_r, res_nxt;
  logic    load;

  assign empty = !vld_r;
  assign res   = res_r;
  assign load  = !vld_r || pop;

  always_comb begin
    vld_nxt = vld_r;
    sub_nxt = sub_r;
    res_nxt = res_r;
    q_pop   = 1'b0;
    if (load) begin
      if (!q_empty) begin
        vld_nxt = 1'b1;
        res_nxt = sub_r ? head.r1 : head.r0;
        if (!sub_r && head.two) begin
          sub_nxt = 1'b1;
        end else begin
          sub_nxt = 1'b0;
          q_pop   = 1'b1;
        end
      end else begin
        vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      sub_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      sub_r <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

### rtl/tile_rle_decoder_unit.sv
// Top level of the tile run-length decoder with its configuration registers.
// Depends on trd_pkg, trd_front, trd_cmd_queue and trd_back.
`timescale 1ns / 1ps

// The decoder takes one compressed byte per cycle and turns it into at most two
// result words of value and count, clipped to the tile size of width times height
// times planes. Each byte passes the parser in the cycle it is accepted, and its
// results go into a queue of four command entries. The output register hands out
// one result word per cycle while the receiver pops, so the sustained rate is one
// byte per cycle. The one exception is a literal run that is cut short by the
// final byte: it yields two words. The first result of a byte passes through the
// queue and then the output register before it is on the output ports. The input
// stalls while the queue holds four commands. The tile size is recomputed
// whenever a configuration register is written.
module tile_rle_decoder_unit import trd_pkg::*; #(
  parameter int unsigned MAX_TILE_SIDE = 64,
  parameter int unsigned MAX_PLANES    = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [BYTE_W-1:0]      in_src_byte,
  input  logic                   in_src_last,
  input  logic                   push,
  output logic                   full,
  output logic [BYTE_W-1:0]      out_run_value,
  output logic [RUN_COUNT_W-1:0] out_run_count,
  output logic                   out_tile_done,
  output logic                   out_tile_short,
  output logic                   empty,
  input  logic                   pop,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int unsigned SIDE_W  = $clog2(MAX_TILE_SIDE + 1);
  localparam int unsigned PL_W    = $clog2(MAX_PLANES + 1);
  localparam int unsigned TOT_W   = 2 * SIDE_W + PL_W;
  localparam int unsigned CMP_W   = (SIDE_W > TILE_DIM_W) ? SIDE_W : TILE_DIM_W;
  localparam int unsigned CMPP_W  = (PL_W > PLANES_W) ? PL_W : PLANES_W;

  localparam logic [1:0] REG_TILE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_TILE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_PLANE_COUNT = 2'd2;

  localparam logic [TILE_DIM_W-1:0] WIDTH_RST  = TILE_DIM_W'(64);
  localparam logic [TILE_DIM_W-1:0] HEIGHT_RST = TILE_DIM_W'(64);
  localparam logic [PLANES_W-1:0]   PLANES_RST = PLANES_W'(1);

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [TILE_DIM_W-1:0] v);
    logic [CMP_W-1:0] vx;
    vx = CMP_W'(v);
    if (v == '0) return SIDE_W'(1);
    if (vx > CMP_W'(MAX_TILE_SIDE)) return SIDE_W'(MAX_TILE_SIDE);
    return SIDE_W'(vx);
  endfunction

  function automatic logic [PL_W-1:0] clamp_planes(input logic [PLANES_W-1:0] v);
    logic [CMPP_W-1:0] vx;
    vx = CMPP_W'(v);
    if (v == '0) return PL_W'(1);
    if (vx > CMPP_W'(MAX_PLANES)) return PL_W'(MAX_PLANES);
    return PL_W'(vx);
  endfunction

  function automatic logic [TOT_W-1:0] tile_total(input logic [TILE_DIM_W-1:0] w,
                                                  input logic [TILE_DIM_W-1:0] h,
                                                  input logic [PLANES_W-1:0] p);
    return TOT_W'(clamp_side(w)) * TOT_W'(clamp_side(h)) * TOT_W'(clamp_planes(p));
  endfunction

  logic [TILE_DIM_W-1:0] width_r, width_nxt, height_r, height_nxt;
  logic [PLANES_W-1:0]   planes_r, planes_nxt;
  logic [TOT_W-1:0]      total_r, total_nxt;
  logic                  cfg_wr;

  logic    in_valid, cmd_push, q_pop, q_full, q_empty;
  cmd_t    cmd, head;
  result_t res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    planes_nxt = planes_r;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_TILE_WIDTH:  width_nxt  = pwdata[TILE_DIM_W-1:0];
        REG_TILE_HEIGHT: height_nxt = pwdata[TILE_DIM_W-1:0];
        REG_PLANE_COUNT: planes_nxt = pwdata[PLANES_W-1:0];
        default: ;
      endcase
    end
    total_nxt = tile_total(width_nxt, height_nxt, planes_nxt);
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TILE_WIDTH:  prdata = 32'(width_r);
      REG_TILE_HEIGHT: prdata = 32'(height_r);
      REG_PLANE_COUNT: prdata = 32'(planes_r);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      planes_r <= PLANES_RST;
      total_r  <= tile_total(WIDTH_RST, HEIGHT_RST, PLANES_RST);
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      planes_r <= planes_nxt;
      total_r  <= total_nxt;
    end
  end

  assign full     = q_full;
  assign in_valid = push && !q_full;

  trd_front #(
    .TOT_W (TOT_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_byte  (in_src_byte),
    .in_last  (in_src_last),
    .total    (total_r),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  trd_cmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_cmd  (cmd),
    .rd_en   (q_pop),
    .rd_cmd  (head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  trd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign out_run_value  = res.run_value;
  assign out_run_count  = res.run_count;
  assign out_tile_done  = res.tile_done;
  assign out_tile_short = res.tile_short;

endmodule

### tb/tb_tile_rle_decoder_unit.sv
// Self-checking testbench for the tile run-length decoder top level.
// Drives compressed bytes and register writes, predicts every run word, compares.
// Depends on trd_pkg and tile_rle_decoder_unit.
`timescale 1ns / 1ps

module tb_tile_rle_decoder_unit;
  import trd_pkg::*;

  localparam int unsigned MAX_SIDE   = 64;
  localparam int unsigned MAX_PL     = 4;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned HOLD_LEN   = 300;
  localparam int unsigned SRC_TARGET = 850;

  localparam logic [3:0] ADDR_TILE_W  = 4'd0;
  localparam logic [3:0] ADDR_TILE_H  = 4'd4;
  localparam logic [3:0] ADDR_PLANES  = 4'd8;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } src_word_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [BYTE_W-1:0]      in_src_byte = '0;
  logic                   in_src_last = 1'b0;
  logic                   push = 1'b0;
  logic                   full;
  logic [BYTE_W-1:0]      out_run_value;
  logic [RUN_COUNT_W-1:0] out_run_count;
  logic                   out_tile_done;
  logic                   out_tile_short;
  logic                   empty;
  logic                   pop = 1'b0;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [3:0]             paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;

  tile_rle_decoder_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_src_byte(in_src_byte), .in_src_last(in_src_last), .push(push), .full(full),
    .out_run_value(out_run_value), .out_run_count(out_run_count),
    .out_tile_done(out_tile_done), .out_tile_short(out_tile_short),
    .empty(empty), .pop(pop),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Shadow of the decoder state and its registers.
  logic [TILE_DIM_W-1:0] tile_w = 7'd64;
  logic [TILE_DIM_W-1:0] tile_h = 7'd64;
  logic [PLANES_W-1:0]   planes = 3'd1;
  phase_t                dec_phase = PH_HEADER;
  logic                  run_literal = 1'b0;
  logic [RUN_LEN_W-1:0]  run_left = '0;
  logic [7:0]            count_hi = '0;
  int unsigned           out_written = 0;
  logic                  dec_finished = 1'b0;
  int unsigned           room_left;

  result_t   step_runs[$];
  result_t   runs_expected[$];
  src_word_t pending_src[$];

  int unsigned mismatches = 0;
  int unsigned src_queued = 0;
  int unsigned idle_cycles = 0;
  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;
  int unsigned push_mode = 0;
  int unsigned pop_mode = 0;
  int unsigned push_gap = 0;
  int unsigned pop_gap = 0;
  int unsigned pop_hold = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_seen = 0;
  logic        offering;
  src_word_t   next_src;

  function automatic int unsigned clip_dim(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned draw_gap(input int unsigned mode);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, 15);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
  endfunction

  task automatic emit_run(input logic [7:0] value, input int unsigned count);
    int unsigned c;
    result_t r;
    c = (count < room_left) ? count : room_left;
    room_left -= c;
    out_written += c;
    if (c != 0) begin
      r.run_value = value;
      r.run_count = c[RUN_COUNT_W-1:0];
      r.tile_done = 1'b0;
      r.tile_short = 1'b0;
      step_runs.push_back(r);
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last);
    int unsigned total;
    logic full_now;
    result_t tail;
    step_runs.delete();
    if (dec_finished) begin
      if (last) begin
        dec_finished = 1'b0;
        out_written = 0;
        dec_phase = PH_HEADER;
      end
    end else begin
      total = clip_dim(tile_w, MAX_SIDE) * clip_dim(tile_h, MAX_SIDE) *
              clip_dim(planes, MAX_PL);
      room_left = (out_written < total) ? total - out_written : 0;
      case (dec_phase)
        PH_COUNT_HI: begin
          count_hi = b;
          if (last) emit_run(8'h00, {b, 8'h00});
          else dec_phase = PH_COUNT_LO;
        end
        PH_COUNT_LO: begin
          run_left = {count_hi, b};
          if (last) emit_run(8'h00, run_left);
          else if (!run_literal) dec_phase = PH_VALUE;
          else dec_phase = (run_left != 0) ? PH_LITERAL : PH_HEADER;
        end
        PH_VALUE: begin
          emit_run(b, run_left);
          run_left = '0;
          dec_phase = PH_HEADER;
        end
        PH_LITERAL: begin
          emit_run(b, 1);
          run_left = run_left - 16'd1;
          if (last) emit_run(8'h00, run_left);
          if (run_left == 0) dec_phase = PH_HEADER;
        end
        default: begin
          dec_phase = PH_HEADER;
          if (!last) begin
            if (b >= 8'd128) begin
              run_literal = 1'b1;
              run_left = 16'(256 - int'(b));
              dec_phase = (run_left == 16'd128) ? PH_COUNT_HI : PH_LITERAL;
            end else begin
              run_literal = 1'b0;
              run_left = 16'(int'(b) + 1);
              dec_phase = (run_left == 16'd128) ? PH_COUNT_HI : PH_VALUE;
            end
          end
        end
      endcase
      full_now = (room_left == 0);
      if (full_now || last) begin
        if (step_runs.size() == 0) begin
          tail = '0;
        end else begin
          tail = step_runs.pop_back();
        end
        tail.tile_done = 1'b1;
        tail.tile_short = !full_now;
        step_runs.push_back(tail);
        dec_phase = PH_HEADER;
        run_left = '0;
        if (last) begin
          out_written = 0;
          dec_finished = 1'b0;
        end else begin
          dec_finished = 1'b1;
        end
      end
      foreach (step_runs[i]) runs_expected.push_back(step_runs[i]);
    end
  endtask

  task automatic check_run;
    result_t want;
    if (runs_expected.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected word: value %h count %0d done %b short %b",
                 out_run_value, out_run_count, out_tile_done, out_tile_short);
      mismatches++;
    end else begin
      want = runs_expected.pop_front();
      if (want.run_value != out_run_value || want.run_count != out_run_count ||
          want.tile_done != out_tile_done || want.tile_short != out_tile_short) begin
        if (mismatches < 10)
          $display("word mismatch: expected %h/%0d/%b/%b, got %h/%0d/%b/%b",
                   want.run_value, want.run_count, want.tile_done, want.tile_short,
                   out_run_value, out_run_count, out_tile_done, out_tile_short);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    in_fire <= rst_n && push && !full;
    out_fire <= rst_n && pop && !empty;
    if (rst_n && push && !full) predict_byte(in_src_byte, in_src_last);
    if (rst_n && pop && !empty) check_run();
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      offering = push && !in_fire;
      if (in_fire) push_gap = draw_gap(push_mode);
      if (!offering) begin
        if (push_gap > 0) begin
          push_gap--;
        end else if (pending_src.size() > 0) begin
          next_src = pending_src.pop_front();
          in_src_byte <= next_src.b;
          in_src_last <= next_src.last;
          offering = 1'b1;
        end
      end
      push <= offering;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        pop_hold = HOLD_LEN;
      end
      if (out_fire) pop_gap = draw_gap(pop_mode);
      if (pop_hold > 0) begin
        pop_hold--;
        pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || in_fire || out_fire || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic last);
    src_word_t w;
    w.b = b;
    w.last = last;
    pending_src.push_back(w);
    src_queued++;
  endtask

  task automatic settle;
    while (pending_src.size() != 0 || push || runs_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (addr)
      ADDR_TILE_W: tile_w = data[TILE_DIM_W-1:0];
      ADDR_TILE_H: tile_h = data[TILE_DIM_W-1:0];
      default:     planes = data[PLANES_W-1:0];
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_check(input logic [3:0] addr, input logic [31:0] want);
    logic [31:0] got;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got != want) begin
      if (mismatches < 10)
        $display("register %h read back %h, expected %h", addr, got, want);
      mismatches++;
    end
  endtask

  task automatic set_tile(input int unsigned w, input int unsigned h, input int unsigned p);
    settle();
    apb_write(ADDR_TILE_W, w);
    apb_write(ADDR_TILE_H, h);
    apb_write(ADDR_PLANES, p);
    apb_check(ADDR_TILE_W, {25'd0, tile_w});
    apb_check(ADDR_TILE_H, {25'd0, tile_h});
    apb_check(ADDR_PLANES, {29'd0, planes});
  endtask

  task automatic queue_tile(input int unsigned n_runs);
    src_word_t body[$];
    src_word_t w;
    int unsigned len;
    int unsigned hi;
    int unsigned lo;
    int unsigned ending;
    int unsigned cut;
    body.delete();
    for (int r = 0; r < n_runs; r++) begin
      case ($urandom_range(0, 9))
        4: begin
          hi = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 1);
          body.push_back('{8'h7F, 1'b0});
          body.push_back('{8'(hi), 1'b0});
          body.push_back('{8'($urandom_range(0, 255)), 1'b0});
          body.push_back('{8'($urandom_range(0, 255)), 1'b0});
        end
        5, 6, 7: begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 6);
          body.push_back('{8'(256 - len), 1'b0});
          for (int i = 0; i < len; i++) body.push_back('{8'($urandom_range(0, 255)), 1'b0});
        end
        8: begin
          lo = $urandom_range(0, 6);
          body.push_back('{8'h80, 1'b0});
          body.push_back('{8'h00, 1'b0});
          body.push_back('{8'(lo), 1'b0});
          for (int i = 0; i < lo; i++) body.push_back('{8'($urandom_range(0, 255)), 1'b0});
        end
        default: begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 126) : $urandom_range(0, 15);
          body.push_back('{8'(len), 1'b0});
          body.push_back('{8'($urandom_range(0, 255)), 1'b0});
        end
      endcase
    end
    ending = $urandom_range(0, 3);
    if (ending == 0) begin
      body.push_back('{8'($urandom_range(0, 255)), 1'b0});
    end else if (ending == 2) begin
      cut = $urandom_range(1, body.size());
      while (body.size() > cut) void'(body.pop_back());
    end
    w = body.pop_back();
    body.push_back('{w.b, 1'b1});
    foreach (body[i]) queue_byte(body[i].b, body[i].last);
  endtask

  initial begin
    int unsigned sel;
    bit          pressed;
    pressed = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_tile(64, 64, 1);
    queue_byte(8'h00, 0); queue_byte(8'hFF, 0);
    queue_byte(8'h7E, 0); queue_byte(8'h00, 0);
    queue_byte(8'h7F, 0); queue_byte(8'h00, 0); queue_byte(8'h05, 0); queue_byte(8'hAA, 0);
    queue_byte(8'h80, 0); queue_byte(8'h00, 0); queue_byte(8'h02, 0);
    queue_byte(8'h11, 0); queue_byte(8'h22, 0);
    queue_byte(8'h80, 0); queue_byte(8'h00, 0); queue_byte(8'h00, 0);
    queue_byte(8'hFF, 0); queue_byte(8'h33, 0);
    queue_byte(8'h05, 1);

    set_tile(1, 1, 1);
    queue_byte(8'h03, 0); queue_byte(8'h44, 0); queue_byte(8'h12, 0); queue_byte(8'h34, 1);

    set_tile(127, 0, 0);
    queue_byte(8'hFC, 0); queue_byte(8'h01, 1);
    queue_byte(8'h7F, 0); queue_byte(8'h02, 1);
    queue_byte(8'h80, 0); queue_byte(8'h00, 0); queue_byte(8'h03, 1);
    queue_byte(8'h02, 0); queue_byte(8'h99, 1);

    set_tile(64, 64, 4);
    queue_tile(4);
    set_tile(127, 127, 7);
    queue_tile(3);

    while (src_queued < SRC_TARGET || !pressed) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        case ($urandom_range(0, 3))
          0: set_tile(0, 0, 0);
          1: set_tile(1, 1, 1);
          2: set_tile(64, 64, 4);
          default: set_tile(127, 127, 7);
        endcase
      end else begin
        set_tile($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(0, 7));
      end
      push_mode = $urandom_range(0, 2);
      pop_mode = $urandom_range(0, 2);

      if (!pressed && src_queued > SRC_TARGET / 2) begin
        // Long receiver hold-off while back-to-back repeat runs keep arriving.
        pressed = 1;
        set_tile(64, 64, 4);
        push_mode = 0;
        @(posedge clk);
        hold_asks++;
        for (int i = 0; i < 60; i++) begin
          queue_byte(8'h00, 0);
          queue_byte(8'($urandom_range(0, 255)), 0);
        end
        queue_byte(8'h00, 1);
      end

      for (int t = $urandom_range(1, 3); t > 0; t--) begin
        if ($urandom_range(0, 4) == 0) begin
          for (int i = $urandom_range(8, 20); i > 0; i--)
            queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        end else begin
          queue_tile($urandom_range(1, 8));
        end
      end
      if ($urandom_range(0, 5) == 0) begin
        queue_byte(8'($urandom_range(0, 15)), 0);
        queue_byte(8'($urandom_range(0, 255)), 0);
      end
    end

    queue_tile(2);
    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
